@@ design/u16u8_pkg.sv @@
package u16u8_pkg;

  localparam int MaxBytes = 6;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } point_enc_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     hold;
    logic [9:0]               hold_bits;
  } enc_result_t;

  // Byte 0 of the result is the first byte of the sequence.
  function automatic point_enc_t encode_point(input logic [20:0] cp);
    point_enc_t r;
    r.bytes = '0;
    if (cp <= 21'h7F) begin
      r.bytes[0] = {1'b0, cp[6:0]};
      r.len = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len = 3'd4;
    end
    return r;
  endfunction

endpackage

@@ design/u16u8_in_if.sv @@
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink (input valid, input code_unit, input string_end, output ready);
endinterface

@@ design/u16u8_out_if.sv @@
interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

@@ design/u16u8_encoder.sv @@
module u16u8_encoder (
  input  logic [15:0]               code_unit,
  input  logic                      string_end,
  input  logic                      held_valid,
  input  logic [9:0]                held_bits,
  output u16u8_pkg::enc_result_t    result
);

  logic                    is_high;
  logic                    is_low;
  logic [20:0]             pair_cp;
  u16u8_pkg::point_enc_t   pair_enc;
  u16u8_pkg::point_enc_t   flush_enc;
  u16u8_pkg::point_enc_t   unit_enc;

  assign is_high = (code_unit >= u16u8_pkg::HighFirst) && (code_unit <= u16u8_pkg::HighLast);
  assign is_low  = (code_unit >= u16u8_pkg::LowFirst) && (code_unit <= u16u8_pkg::LowLast);

  // The low ten bits of each surrogate concatenate into the code point offset.
  assign pair_cp   = u16u8_pkg::SuppBase + {1'b0, held_bits, code_unit[9:0]};
  assign pair_enc  = u16u8_pkg::encode_point(pair_cp);
  assign flush_enc = u16u8_pkg::encode_point({5'd0, 6'b110110, held_bits});
  assign unit_enc  = u16u8_pkg::encode_point({5'd0, code_unit});

  always_comb begin
    result = '0;
    if (held_valid && is_low) begin
      result.bytes[3:0] = pair_enc.bytes;
      result.cnt = pair_enc.len;
    end else begin
      result.hold = is_high && !string_end;
      result.hold_bits = result.hold ? code_unit[9:0] : 10'd0;
      if (held_valid) begin
        // The flushed surrogate always takes three bytes; the current unit follows unless it is held.
        result.bytes[2:0] = flush_enc.bytes[2:0];
        if (!result.hold) begin
          result.bytes[5:3] = unit_enc.bytes[2:0];
          result.cnt = 3'd3 + unit_enc.len;
        end else begin
          result.cnt = 3'd3;
        end
      end else if (!result.hold) begin
        result.bytes[3:0] = unit_enc.bytes;
        result.cnt = unit_enc.len;
      end
    end
  end

endmodule

@@ design/utf16_to_utf8_converter.sv @@
// UTF-16 to UTF-8 converter.
// The units channel takes one UTF-16 code unit a word, with string_end on the
// last unit of a string. The octets channel gives one UTF-8 byte a word, with
// run_last on the last byte that a unit caused.
// A unit sits in the input register, is encoded there and moves into a
// six-byte burst register, from which the bytes leave one per cycle while
// the receiver is ready.
// Throughput is one unit per cycle while each unit gives at most one byte
// and the receiver takes every byte; otherwise the output side sets the pace
// at one byte per cycle, and a unit can cause up to six bytes. A high
// surrogate that is held back gives no bytes.
// When the receiver stalls, the burst register holds its bytes and the input
// register still takes one more unit before units.ready drops.
// Reset (rst, synchronous) empties both registers and drops any held
// surrogate.
module utf16_to_utf8_converter (
  input  logic          clk,
  input  logic          rst,
  u16u8_in_if.sink      units,
  u16u8_out_if.source   octets
);

  logic                                   inreg_valid;
  logic [15:0]                            inreg_unit;
  logic                                   inreg_end;
  logic                                   held_valid;
  logic [9:0]                             held_bits;
  logic [u16u8_pkg::MaxBytes-1:0][7:0]    burst;
  logic [2:0]                             burst_cnt;
  logic                                   take;
  logic                                   move;
  logic                                   accept;
  u16u8_pkg::enc_result_t                 enc;

  u16u8_encoder encoder (
    .code_unit  (inreg_unit),
    .string_end (inreg_end),
    .held_valid (held_valid),
    .held_bits  (held_bits),
    .result     (enc)
  );

  assign take   = octets.valid && octets.ready;
  assign move   = inreg_valid && ((burst_cnt == 3'd0) || ((burst_cnt == 3'd1) && take));
  assign accept = units.valid && units.ready;

  assign units.ready     = !inreg_valid || move;
  assign octets.valid    = burst_cnt != 3'd0;
  assign octets.out_byte = burst[0];
  assign octets.run_last = burst_cnt == 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inreg_valid <= 1'b0;
      burst_cnt   <= 3'd0;
      held_valid  <= 1'b0;
      held_bits   <= 10'd0;
    end else begin
      if (accept) begin
        inreg_valid <= 1'b1;
      end else if (move) begin
        inreg_valid <= 1'b0;
      end
      if (move) begin
        burst_cnt  <= enc.cnt;
        held_valid <= enc.hold;
        held_bits  <= enc.hold_bits;
      end else if (take) begin
        burst_cnt <= burst_cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inreg_unit <= units.code_unit;
      inreg_end  <= units.string_end;
    end
    if (move) begin
      burst <= enc.bytes;
    end else if (take) begin
      burst <= {8'h00, burst[u16u8_pkg::MaxBytes-1:1]};
    end
  end

endmodule
